// File: rtl/pds_pkg.sv
// ----------------------------------------------------------------------------
// pds_pkg: shared types and constants of the pll divider search
// widths, search limits, status codes and the divider word packing
// ----------------------------------------------------------------------------
package pds_pkg;

  // field widths
  localparam int unsigned RefW  = 26;
  localparam int unsigned TgtW  = 32;
  localparam int unsigned SrcW  = 2;
  localparam int unsigned StW   = 2;
  localparam int unsigned PdivW = 3;
  localparam int unsigned MfdW  = 8;
  localparam int unsigned ShW   = 3;
  localparam int unsigned WordW = 32;
  // reference times multiplier, at most 2^26 * 150 < 2^34
  localparam int unsigned XW    = 34;
  // predivider * 2 * 2^shift, at most 192
  localparam int unsigned DivW  = 8;
  // target times divisor
  localparam int unsigned MulW  = TgtW + DivW;

  // search limits
  localparam logic [PdivW-1:0] PdivLo  = 3'd1;
  localparam logic [PdivW-1:0] PdivHi  = 3'd6;
  localparam logic [MfdW-1:0]  MfdLo   = 8'd10;
  localparam logic [MfdW-1:0]  MfdHi   = 8'd150;
  localparam logic [ShW-1:0]   ShiftLo = 3'd0;
  localparam logic [ShW-1:0]   ShiftHi = 3'd4;

  // reference source codes
  localparam logic [SrcW-1:0] SrcRc   = 2'd0;
  localparam logic [SrcW-1:0] SrcXtal = 2'd1;

  // status codes
  localparam logic [StW-1:0] StFound   = 2'd0;
  localparam logic [StW-1:0] StInvalid = 2'd1;
  localparam logic [StW-1:0] StNone    = 2'd2;

  // reset value of the internal rc frequency register
  localparam logic [RefW-1:0] RcResetHz = 26'd16000000;

  // one candidate setting handed to the check unit
  typedef struct packed {
    logic             valid;
    logic [XW-1:0]    x;
    logic [DivW-1:0]  div;
    logic [PdivW-1:0] p;
    logic [MfdW-1:0]  m;
    logic [ShW-1:0]   s;
  } cand_t;

  // check unit report back to the sequencer
  typedef struct packed {
    logic             hit;
    logic             busy;
    logic [PdivW-1:0] p;
    logic [MfdW-1:0]  m;
    logic [ShW-1:0]   s;
  } chk_res_t;

  // shift at bits 18..16, predivider at bits 14..12, multiplier at bits 7..0
  function automatic logic [WordW-1:0] pack_word(logic [ShW-1:0] s,
                                                 logic [PdivW-1:0] p,
                                                 logic [MfdW-1:0] m);
    return {13'd0, s, 1'b0, p, 4'd0, m};
  endfunction

endpackage

// File: rtl/pds_req_if.sv
// ----------------------------------------------------------------------------
// pds_req_if: request channel
// valid/ready handshake carrying the reference source, crystal and target
// ----------------------------------------------------------------------------
interface pds_req_if import pds_pkg::*; ();

  logic            valid;
  logic            ready;
  logic [SrcW-1:0] reference_source;
  logic [RefW-1:0] crystal_hz;
  logic [TgtW-1:0] target_hz;

  modport source (output valid, output reference_source, output crystal_hz,
                  output target_hz, input ready);
  modport sink (input valid, input reference_source, input crystal_hz,
                input target_hz, output ready);

endinterface

// File: rtl/pds_rsp_if.sv
// ----------------------------------------------------------------------------
// pds_rsp_if: response channel
// valid/ready handshake carrying status, chosen settings and divider word
// ----------------------------------------------------------------------------
interface pds_rsp_if import pds_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [StW-1:0]   status;
  logic [PdivW-1:0] predivider;
  logic [MfdW-1:0]  multiplier;
  logic [ShW-1:0]   output_shift;
  logic [WordW-1:0] divider_word;

  modport source (output valid, output status, output predivider,
                  output multiplier, output output_shift, output divider_word,
                  input ready);
  modport sink (input valid, input status, input predivider,
                input multiplier, input output_shift, input divider_word,
                output ready);

endinterface

// File: rtl/pds_chk.sv
// ----------------------------------------------------------------------------
// pds_chk: shared candidate check unit
// two-stage multiply and compare: target*div registered, then tests
// target*div <= ref*m < (target+1)*div, which is floor(ref*m/div) == target
// ----------------------------------------------------------------------------
module pds_chk import pds_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            flush_i,
  input  logic [TgtW-1:0] target_i,
  input  cand_t           cand_i,
  output chk_res_t        res_o
);

  logic             v_q;
  logic [MulW-1:0]  prod_q;
  logic [XW-1:0]    x_q;
  logic [DivW-1:0]  div_q;
  logic [PdivW-1:0] p_q;
  logic [MfdW-1:0]  m_q;
  logic [ShW-1:0]   s_q;
  logic [MulW:0]    diff;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= cand_i.valid && !flush_i;
    end
  end

  // multiply stage
  always_ff @(posedge clk_i) begin
    if (cand_i.valid) begin
      prod_q <= MulW'(target_i) * MulW'(cand_i.div);
      x_q    <= cand_i.x;
      div_q  <= cand_i.div;
      p_q    <= cand_i.p;
      m_q    <= cand_i.m;
      s_q    <= cand_i.s;
    end
  end

  // compare stage: no borrow and remainder below the divisor
  assign diff = {1'b0, MulW'(x_q)} - {1'b0, prod_q};

  assign res_o.hit  = v_q && !diff[MulW] && (diff[MulW-1:0] < MulW'(div_q));
  assign res_o.busy = v_q;
  assign res_o.p    = p_q;
  assign res_o.m    = m_q;
  assign res_o.s    = s_q;

endmodule

// File: rtl/pll_divider_search_unit.sv
// ----------------------------------------------------------------------------
// pll_divider_search_unit: pll divider search
// an invalid request skips the search and is answered from the done state; a
// search ends at the first hit, or once every candidate has been tried and
// the check unit is empty
// one request at a time: a new request is taken only while the unit is idle
// reset: rc frequency register to 16 MHz, idle, no response pending
// ----------------------------------------------------------------------------
module pll_divider_search_unit import pds_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [RefW-1:0]  cfg_wdata_i,
  pds_req_if.sink          req_i,
  pds_rsp_if.source        rsp_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [RefW-1:0]  rc_q;
  logic [RefW-1:0]  ref_q, ref_sel;
  logic [TgtW-1:0]  tgt_q;
  logic [PdivW-1:0] p_q, p_d;
  logic [MfdW-1:0]  m_q, m_d;
  logic [ShW-1:0]   s_q, s_d;
  logic [XW-1:0]    x_q, x_d;
  logic             issue_q, issue_d;
  logic [StW-1:0]   pend_st_q, pend_st_d;
  logic [PdivW-1:0] pend_p_q, pend_p_d;
  logic [MfdW-1:0]  pend_m_q, pend_m_d;
  logic [ShW-1:0]   pend_s_q, pend_s_d;
  logic             rsp_valid_q;
  logic [StW-1:0]   rsp_st_q;
  logic [PdivW-1:0] rsp_p_q;
  logic [MfdW-1:0]  rsp_m_q;
  logic [ShW-1:0]   rsp_s_q;
  logic             req_beat, rsp_load, bad_req, last_cand, flush;
  cand_t            cand;
  chk_res_t         chk_res;

  // rc frequency register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q <= RcResetHz;
    end else if (cfg_we_i) begin
      rc_q <= cfg_wdata_i;
    end
  end

  // request decode
  assign req_i.ready = (state_q == S_IDLE);
  assign req_beat    = req_i.valid && req_i.ready;
  assign bad_req     = (req_i.reference_source != SrcRc &&
                        req_i.reference_source != SrcXtal) ||
                       (req_i.target_hz == '0);
  assign ref_sel     = (req_i.reference_source == SrcRc) ? rc_q : req_i.crystal_hz;
  assign last_cand   = (p_q == PdivHi) && (m_q == MfdHi) && (s_q == ShiftHi);
  assign rsp_load    = (state_q == S_DONE) && (!rsp_valid_q || rsp_o.ready);
  assign flush       = (state_q == S_RUN) && chk_res.hit;

  // candidate to the check unit
  assign cand.valid = issue_q && (state_q == S_RUN);
  assign cand.x     = x_q;
  assign cand.div   = DivW'({p_q, 1'b0}) << s_q;
  assign cand.p     = p_q;
  assign cand.m     = m_q;
  assign cand.s     = s_q;

  pds_chk u_chk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .flush_i  (flush),
    .target_i (tgt_q),
    .cand_i   (cand),
    .res_o    (chk_res)
  );

  // search sequencer
  always_comb begin
    state_d   = state_q;
    p_d       = p_q;
    m_d       = m_q;
    s_d       = s_q;
    x_d       = x_q;
    issue_d   = issue_q;
    pend_st_d = pend_st_q;
    pend_p_d  = pend_p_q;
    pend_m_d  = pend_m_q;
    pend_s_d  = pend_s_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_beat) begin
          p_d       = PdivLo;
          m_d       = MfdLo;
          s_d       = ShiftLo;
          x_d       = XW'({ref_sel, 3'b0}) + XW'({ref_sel, 1'b0});
          pend_st_d = StInvalid;
          pend_p_d  = '0;
          pend_m_d  = '0;
          pend_s_d  = '0;
          issue_d   = !bad_req;
          state_d   = bad_req ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        // step shift, then multiplier, then predivider
        if (issue_q) begin
          if (last_cand) begin
            issue_d = 1'b0;
          end
          if (s_q == ShiftHi) begin
            s_d = ShiftLo;
            if (m_q == MfdHi) begin
              m_d = MfdLo;
              p_d = p_q + 3'd1;
              x_d = XW'({ref_q, 3'b0}) + XW'({ref_q, 1'b0});
            end else begin
              m_d = m_q + 8'd1;
              x_d = x_q + XW'(ref_q);
            end
          end else begin
            s_d = s_q + 3'd1;
          end
        end
        if (chk_res.hit) begin
          pend_st_d = StFound;
          pend_p_d  = chk_res.p;
          pend_m_d  = chk_res.m;
          pend_s_d  = chk_res.s;
          issue_d   = 1'b0;
          state_d   = S_DONE;
        end else if (!issue_q && !chk_res.busy) begin
          pend_st_d = StNone;
          state_d   = S_DONE;
        end
      end
      S_DONE: begin
        if (rsp_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      issue_q <= 1'b0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
    end
  end

  // search datapath registers
  always_ff @(posedge clk_i) begin
    p_q       <= p_d;
    m_q       <= m_d;
    s_q       <= s_d;
    x_q       <= x_d;
    pend_st_q <= pend_st_d;
    pend_p_q  <= pend_p_d;
    pend_m_q  <= pend_m_d;
    pend_s_q  <= pend_s_d;
    if (req_beat) begin
      ref_q <= ref_sel;
      tgt_q <= req_i.target_hz;
    end
  end

  // response output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_st_q <= pend_st_q;
      rsp_p_q  <= pend_p_q;
      rsp_m_q  <= pend_m_q;
      rsp_s_q  <= pend_s_q;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_st_q;
  assign rsp_o.predivider   = rsp_p_q;
  assign rsp_o.multiplier   = rsp_m_q;
  assign rsp_o.output_shift = rsp_s_q;
  assign rsp_o.divider_word = pack_word(rsp_s_q, rsp_p_q, rsp_m_q);

`ifndef ASSERT_OFF
  // check unit holds nothing while the sequencer is idle
  a_chk_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !chk_res.busy)
    else $error("check unit busy while idle");

  // a hit during the search always ends it
  a_hit_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RUN) && chk_res.hit) |=> (state_q == S_DONE))
    else $error("search continued after a hit");

  // found results carry a multiplier and predivider inside the search range
  a_found_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == StFound)) |->
      ((rsp_o.multiplier >= MfdLo) && (rsp_o.multiplier <= MfdHi) &&
       (rsp_o.predivider >= PdivLo) && (rsp_o.predivider <= PdivHi)))
    else $error("found result outside search range");

  // results that are not found carry a zero divider word
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != StFound)) |-> (rsp_o.divider_word == '0))
    else $error("nonzero divider word on a miss");
`endif

endmodule
